// ===== src/serial_frame_to_mouse_reports_defines.svh =====
// Assertion macros shared by the RTL that checks itself.
`ifndef SERIAL_FRAME_TO_MOUSE_REPORTS_DEFINES_SVH
`define SERIAL_FRAME_TO_MOUSE_REPORTS_DEFINES_SVH

// Clocked check, quiet while reset is held.
`define SFMR_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked implication, quiet while reset is held.
`define SFMR_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

`endif

// ===== src/sfmr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sfmr_pkg;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_HOME    = 5'b00010,
    S_MOVE    = 5'b00100,
    S_PRESS   = 5'b01000,
    S_RELEASE = 5'b10000
  } state_t;

  // Result of one pass through the clamp/subtract unit.
  typedef struct packed {
    logic signed [7:0]  step_x;
    logic signed [7:0]  step_y;
    logic signed [13:0] rem_x;
    logic signed [13:0] rem_y;
    logic               drained;
  } step_res_t;

  localparam logic signed [13:0] STEP_LIMIT     = 14'sd127;
  localparam logic signed [13:0] STEP_LIMIT_NEG = -14'sd127;
  localparam logic signed [7:0]  STEP_MAX       = 8'sd127;
  localparam logic signed [7:0]  STEP_MIN       = -8'sd127;

  localparam logic signed [13:0] HOME_LIMIT     = 14'sd7874;
  localparam logic signed [13:0] HOME_LIMIT_NEG = -14'sd7874;
  localparam logic signed [13:0] HOME_X_RESET   = -14'sd4000;
  localparam logic signed [13:0] HOME_Y_RESET   = -14'sd5000;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_HOME_X = 2'd0;
  localparam logic [1:0] REG_HOME_Y = 2'd1;

  // Report kinds.
  localparam logic KIND_MOVE   = 1'b0;
  localparam logic KIND_BUTTON = 1'b1;

  // A click or init byte counts only when it holds this value.
  localparam logic [7:0] FLAG_SET = 8'd1;

  // Byte positions within a frame header.
  localparam logic [17:0] POS_COUNT_LO   = 18'd0;
  localparam logic [17:0] POS_COUNT_HI   = 18'd1;
  localparam logic [17:0] POS_CLICK      = 18'd2;
  localparam logic [17:0] POS_INIT       = 18'd3;
  localparam logic [17:0] POS_FIRST_PAIR = 18'd4;

  // Saturate a homing register value to the legal range.
  function automatic logic signed [13:0] sat_home(input logic signed [13:0] v);
    logic signed [13:0] r;
    r = v;
    if (v > HOME_LIMIT) r = HOME_LIMIT;
    if (v < HOME_LIMIT_NEG) r = HOME_LIMIT_NEG;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/sfmr_step_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Clamp both homing remainders to one move and subtract it.
module sfmr_step_unit (
  input  wire logic signed [13:0] rem_x,
  input  wire logic signed [13:0] rem_y,
  output sfmr_pkg::step_res_t     res
);
  import sfmr_pkg::*;

  function automatic logic signed [7:0] clamp_step(input logic signed [13:0] v);
    logic signed [7:0] r;
    r = v[7:0];
    if (v > STEP_LIMIT) r = STEP_MAX;
    if (v < STEP_LIMIT_NEG) r = STEP_MIN;
    return r;
  endfunction

  logic signed [7:0]  sx;
  logic signed [7:0]  sy;
  logic signed [13:0] nx;
  logic signed [13:0] ny;
  logic               drained;

  assign sx = clamp_step(rem_x);
  assign sy = clamp_step(rem_y);
  assign nx = rem_x - {{6{sx[7]}}, sx};
  assign ny = rem_y - {{6{sy[7]}}, sy};
  assign drained = (nx == 14'sd0) && (ny == 14'sd0);

  // Pack in field order: step_x, step_y, rem_x, rem_y, drained.
  assign res = {sx, sy, nx, ny, drained};

endmodule
`default_nettype wire

// ===== src/serial_frame_to_mouse_reports.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Serial frame to mouse report converter. Each received byte is one input word; a frame is
// a 16-bit little-endian point count, a click byte, an init byte (each flag set only when
// the byte equals 1) and then that many signed (dx, dy) byte pairs. An init byte that is
// set issues the configured homing displacement as a run of relative moves clamped to
// +-127; every dy byte issues one move with its dx; at frame end a set click adds a
// left-button press and a release. out_tlast marks the final report caused by a byte.
// Timing: a byte is taken when the block is idle; the reports it causes then
// leave at one per cycle while out_tready is high, and in_tready stays low until the last
// of them is in the output register. A homing init byte holds the input while the single
// clamp/subtract unit drains both remainders, one move per cycle while the output register
// can take it; a dy byte holds it for its one move, and a set click at frame end holds it
// for a press and a release more. A byte that causes no report leaves the block ready at
// once; output stalls lengthen the hold. Homing registers saturate to +-7874 as they are
// written; write them only while the block is idle.
module serial_frame_to_mouse_reports (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  // report stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [7:0] move_x, [15:8] move_y, [16] left_pressed
  output logic [0:0]       out_tuser,  // [0] report_kind
  output logic             out_tlast,  // last
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [13:0] cfg_wdata
);
  import sfmr_pkg::*;

  `include "serial_frame_to_mouse_reports_defines.svh"

  state_t             state_r, state_nxt;
  logic [17:0]        byte_pos_r, byte_pos_nxt;
  logic [15:0]        point_total_r, point_total_nxt;
  logic               click_r, click_nxt;
  logic               frame_done_r, frame_done_nxt;
  logic [7:0]         held_x_r, held_x_nxt;
  logic [7:0]         pair_y_r, pair_y_nxt;
  logic signed [13:0] rem_x_r, rem_x_nxt;
  logic signed [13:0] rem_y_r, rem_y_nxt;
  logic signed [13:0] home_x_r, home_x_nxt;
  logic signed [13:0] home_y_r, home_y_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_kind_r, out_kind_nxt;
  logic [7:0]         out_x_r, out_x_nxt;
  logic [7:0]         out_y_r, out_y_nxt;
  logic               out_left_r, out_left_nxt;
  logic               out_last_r, out_last_nxt;

  logic               in_fire;
  logic               slot_free;
  logic [17:0]        pos_inc;
  logic [17:0]        frame_len;
  logic               pair_done;
  logic               header_done;
  step_res_t          step;

  sfmr_step_unit u_step (
    .rem_x (rem_x_r),
    .rem_y (rem_y_r),
    .res   (step)
  );

  assign in_tready   = (state_r == S_IDLE);
  assign in_fire     = in_tvalid && in_tready;
  // The output register can take a report when empty or being drained this cycle.
  assign slot_free   = !out_valid_r || out_tready;
  assign pos_inc     = byte_pos_r + 18'd1;
  assign frame_len   = {1'b0, point_total_r, 1'b0} + POS_FIRST_PAIR;
  assign pair_done   = (pos_inc == frame_len);
  assign header_done = (point_total_r == 16'd0);

  always_comb begin
    state_nxt       = state_r;
    byte_pos_nxt    = byte_pos_r;
    point_total_nxt = point_total_r;
    click_nxt       = click_r;
    frame_done_nxt  = frame_done_r;
    held_x_nxt      = held_x_r;
    pair_y_nxt      = pair_y_r;
    rem_x_nxt       = rem_x_r;
    rem_y_nxt       = rem_y_r;
    home_x_nxt      = home_x_r;
    home_y_nxt      = home_y_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_kind_nxt    = out_kind_r;
    out_x_nxt       = out_x_r;
    out_y_nxt       = out_y_r;
    out_left_nxt    = out_left_r;
    out_last_nxt    = out_last_r;

    // Configuration writes; unknown indexes drop.
    if (cfg_we) begin
      case (cfg_index)
        REG_HOME_X: home_x_nxt = sat_home(cfg_wdata);
        REG_HOME_Y: home_y_nxt = sat_home(cfg_wdata);
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (byte_pos_r)
            POS_COUNT_LO: begin
              point_total_nxt = {8'd0, in_tdata};
              byte_pos_nxt    = POS_COUNT_HI;
            end
            POS_COUNT_HI: begin
              point_total_nxt = {in_tdata, point_total_r[7:0]};
              byte_pos_nxt    = POS_CLICK;
            end
            POS_CLICK: begin
              click_nxt    = (in_tdata == FLAG_SET);
              byte_pos_nxt = POS_INIT;
            end
            POS_INIT: begin
              // An empty frame closes right here.
              frame_done_nxt = header_done;
              byte_pos_nxt   = header_done ? POS_COUNT_LO : POS_FIRST_PAIR;
              if ((in_tdata == FLAG_SET) && ((home_x_r != 14'sd0) || (home_y_r != 14'sd0)))
              begin
                rem_x_nxt = home_x_r;
                rem_y_nxt = home_y_r;
                state_nxt = S_HOME;
              end else if (header_done && click_r) begin
                state_nxt = S_PRESS;
              end
            end
            default: begin
              if (!byte_pos_r[0]) begin
                // dx byte: hold for its partner.
                held_x_nxt   = in_tdata;
                byte_pos_nxt = pos_inc;
              end else begin
                pair_y_nxt     = in_tdata;
                frame_done_nxt = pair_done;
                byte_pos_nxt   = pair_done ? POS_COUNT_LO : pos_inc;
                state_nxt      = S_MOVE;
              end
            end
          endcase
        end
      end

      S_HOME: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_MOVE;
          out_x_nxt     = step.step_x;
          out_y_nxt     = step.step_y;
          out_left_nxt  = 1'b0;
          out_last_nxt  = 1'b0;
          rem_x_nxt     = step.rem_x;
          rem_y_nxt     = step.rem_y;
          if (step.drained) begin
            if (frame_done_r && click_r) begin
              state_nxt = S_PRESS;
            end else begin
              out_last_nxt = 1'b1;
              state_nxt    = S_IDLE;
            end
          end
        end
      end

      S_MOVE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_MOVE;
          out_x_nxt     = held_x_r;
          out_y_nxt     = pair_y_r;
          out_left_nxt  = 1'b0;
          out_last_nxt  = !(frame_done_r && click_r);
          state_nxt     = (frame_done_r && click_r) ? S_PRESS : S_IDLE;
        end
      end

      S_PRESS: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_BUTTON;
          out_x_nxt     = 8'd0;
          out_y_nxt     = 8'd0;
          out_left_nxt  = 1'b1;
          out_last_nxt  = 1'b0;
          state_nxt     = S_RELEASE;
        end
      end

      S_RELEASE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_BUTTON;
          out_x_nxt     = 8'd0;
          out_y_nxt     = 8'd0;
          out_left_nxt  = 1'b0;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      byte_pos_r    <= POS_COUNT_LO;
      point_total_r <= 16'd0;
      click_r       <= 1'b0;
      frame_done_r  <= 1'b0;
      held_x_r      <= 8'd0;
      rem_x_r       <= 14'sd0;
      rem_y_r       <= 14'sd0;
      home_x_r      <= HOME_X_RESET;
      home_y_r      <= HOME_Y_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      byte_pos_r    <= byte_pos_nxt;
      point_total_r <= point_total_nxt;
      click_r       <= click_nxt;
      frame_done_r  <= frame_done_nxt;
      held_x_r      <= held_x_nxt;
      rem_x_r       <= rem_x_nxt;
      rem_y_r       <= rem_y_nxt;
      home_x_r      <= home_x_nxt;
      home_y_r      <= home_y_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    pair_y_r   <= pair_y_nxt;
    out_kind_r <= out_kind_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_left_r <= out_left_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {7'd0, out_left_r, out_y_r, out_x_r};
  assign out_tuser[0] = out_kind_r;
  assign out_tlast    = out_last_r;

  // Homing only runs while something is left to drain.
  `SFMR_ASSERT_IMP(a_home_nonzero, state_r == S_HOME,
    (rem_x_r != 14'sd0) || (rem_y_r != 14'sd0), "homing with both remainders zero")
  // Button reports follow only a set click byte.
  `SFMR_ASSERT_IMP(a_click_only, (state_r == S_PRESS) || (state_r == S_RELEASE),
    click_r && frame_done_r, "button report without a click request")
  // A press is always followed by its release, so it never closes a byte's run.
  `SFMR_ASSERT_IMP(a_press_not_last, out_valid_r && (out_kind_r == KIND_BUTTON) && out_left_r,
    !out_last_r, "press report marked last")
  // Input is held off while the output register waits on a run still in progress.
  `SFMR_ASSERT_IMP(a_busy_no_accept, state_r != S_IDLE, !in_tready,
    "input taken while reports are pending")

endmodule
`default_nettype wire
